/* rtl/tpc_pkg.sv */
package tpc_pkg;

    // Field widths
    localparam int CW   = 32;           // coordinate width, signed Q16.16
    localparam int SW   = 16;           // shade width
    localparam int PW   = 2 * CW;       // one coordinate product
    localparam int DW   = PW + 4;       // plane distance, signed, with headroom
    localparam int MW   = CW + 1;       // magnitude of an edge delta
    localparam int QW   = CW + 1;       // quotient of the crossing division
    localparam int NW   = DW + MW;      // numerator of the crossing division
    localparam int SUMW = CW + 3;       // crossing coordinate before saturation
    localparam int CNTW = $clog2(MW);   // bit counter of the serial unit
    localparam int AW   = 5;            // configuration address width

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_PPX = 3'd0;
    localparam reg_idx_t REG_PPY = 3'd1;
    localparam reg_idx_t REG_PPZ = 3'd2;
    localparam reg_idx_t REG_PNX = 3'd3;
    localparam reg_idx_t REG_PNY = 3'd4;
    localparam reg_idx_t REG_PNZ = 3'd5;

    localparam logic signed [CW-1:0] PPZ_RESET = 32'sd6554;
    localparam logic signed [CW-1:0] PNZ_RESET = 32'sd65536;

    typedef logic [1:0] axis_t;
    localparam axis_t AX_X = 2'd0;
    localparam axis_t AX_Y = 2'd1;
    localparam axis_t AX_Z = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vtx_t;

    // One classified triangle travelling from the front to the back.
    typedef struct packed {
        vtx_t [2:0]           v;
        logic [2:0][DW-1:0]   d;
        logic [2:0]           ins;
        logic [SW-1:0]        shade;
    } job_t;

    // One result triangle.
    typedef struct packed {
        vtx_t [2:0]    v;
        logic [SW-1:0] shade;
        logic          last;
    } piece_t;

    function automatic logic signed [CW-1:0] vtx_axis(vtx_t v, axis_t k);
        logic signed [CW-1:0] r;
        case (k)
            AX_X:    r = v.x;
            AX_Y:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tpc_front.sv */
module tpc_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tpc_pkg::vtx_t [2:0]      in_v,
    input  logic [tpc_pkg::SW-1:0]   in_shade,
    input  tpc_pkg::vtx_t            plane_p,
    input  tpc_pkg::vtx_t            plane_n,
    output logic                     job_valid,
    output tpc_pkg::job_t            job,
    input  logic                     job_ready
);

    // Stage A: products, stage B: dot products, stage C: distances and class.
    logic                               a_valid_reg;
    tpc_pkg::vtx_t [2:0]                a_v_reg;
    logic [tpc_pkg::SW-1:0]             a_shade_reg;
    logic signed [tpc_pkg::PW-1:0]      a_pv_reg [3][3];
    logic signed [tpc_pkg::PW-1:0]      a_pp_reg [3];
    logic signed [tpc_pkg::PW-1:0]      pv_next [3][3];
    logic signed [tpc_pkg::PW-1:0]      pp_next [3];

    logic                               b_valid_reg;
    tpc_pkg::vtx_t [2:0]                b_v_reg;
    logic [tpc_pkg::SW-1:0]             b_shade_reg;
    logic signed [tpc_pkg::DW-1:0]      b_sv_reg [3];
    logic signed [tpc_pkg::DW-1:0]      b_sp_reg;
    logic signed [tpc_pkg::DW-1:0]      sv_next [3];
    logic signed [tpc_pkg::DW-1:0]      sp_next;

    logic                               c_valid_reg;
    tpc_pkg::job_t                      c_job_reg;
    tpc_pkg::job_t                      c_job_next;

    logic a_free, b_free, c_free;

    assign c_free   = !c_valid_reg || job_ready;
    assign b_free   = !b_valid_reg || c_free;
    assign a_free   = !a_valid_reg || b_free;
    assign in_ready = a_free;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pv_next[k][j] = tpc_pkg::PW'(tpc_pkg::vtx_axis(in_v[k], 2'(j)))
                              * tpc_pkg::PW'(tpc_pkg::vtx_axis(plane_n, 2'(j)));
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            pp_next[j] = tpc_pkg::PW'(tpc_pkg::vtx_axis(plane_p, 2'(j)))
                       * tpc_pkg::PW'(tpc_pkg::vtx_axis(plane_n, 2'(j)));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sv_next[k] = tpc_pkg::DW'(a_pv_reg[k][0]) + tpc_pkg::DW'(a_pv_reg[k][1])
                       + tpc_pkg::DW'(a_pv_reg[k][2]);
        end
        sp_next = tpc_pkg::DW'(a_pp_reg[0]) + tpc_pkg::DW'(a_pp_reg[1])
                + tpc_pkg::DW'(a_pp_reg[2]);
    end

    always_comb
    begin
        c_job_next.v     = b_v_reg;
        c_job_next.shade = b_shade_reg;
        for (int k = 0; k < 3; k++)
        begin
            c_job_next.d[k]   = b_sv_reg[k] - b_sp_reg;
            c_job_next.ins[k] = !c_job_next.d[k][tpc_pkg::DW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= in_valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
            if (c_free)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && in_valid)
        begin
            a_v_reg     <= in_v;
            a_shade_reg <= in_shade;
            a_pv_reg    <= pv_next;
            a_pp_reg    <= pp_next;
        end
        if (b_free && a_valid_reg)
        begin
            b_v_reg     <= a_v_reg;
            b_shade_reg <= a_shade_reg;
            b_sv_reg    <= sv_next;
            b_sp_reg    <= sp_next;
        end
        if (c_free && b_valid_reg)
            c_job_reg <= c_job_next;
    end

    assign job_valid = c_valid_reg;
    assign job       = c_job_reg;

endmodule

/* rtl/tpc_xdiv.sv */
module tpc_xdiv
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [tpc_pkg::CW-1:0] a,
    input  logic signed [tpc_pkg::CW-1:0] b,
    input  logic [tpc_pkg::DW-1:0]        da,
    input  logic [tpc_pkg::DW-1:0]        db,
    output logic                          done,
    output logic signed [tpc_pkg::CW-1:0] res
);

    // One crossing coordinate: a +- round(|b-a| * da / (da - db)).
    // Shift-add multiply, then restoring division, one bit per cycle each.
    typedef enum logic [1:0] {X_IDLE, X_MUL, X_DIV, X_FIN} xstate_t;

    xstate_t                        state_reg;
    logic [tpc_pkg::CNTW-1:0]       cnt_reg;
    logic                           done_reg;
    logic                           neg_reg;
    logic signed [tpc_pkg::CW-1:0]  a_reg;
    logic [tpc_pkg::MW-1:0]         mag_reg;
    logic [tpc_pkg::DW-1:0]         da_reg;
    logic [tpc_pkg::DW-1:0]         den_reg;
    logic [tpc_pkg::NW-1:0]         acc_reg;
    logic [tpc_pkg::DW-1:0]         r_reg;
    logic [tpc_pkg::QW-1:0]         q_reg;
    logic signed [tpc_pkg::CW-1:0]  res_reg;

    logic signed [tpc_pkg::MW-1:0]  delta;
    logic [tpc_pkg::NW-1:0]         acc_next;
    logic [tpc_pkg::QW-1:0]         num_lo;
    logic [tpc_pkg::DW:0]           rs;
    logic                           ge;
    logic                           up;
    logic [tpc_pkg::QW:0]           qr;
    logic signed [tpc_pkg::SUMW-1:0] sum;
    logic                           fits;
    logic signed [tpc_pkg::CW-1:0]  sat;

    always_comb
    begin
        delta    = tpc_pkg::MW'(b) - tpc_pkg::MW'(a);
        acc_next = (acc_reg << 1)
                 + (mag_reg[cnt_reg] ? tpc_pkg::NW'(da_reg) : '0);
        num_lo   = acc_reg[tpc_pkg::QW-1:0];
        rs       = {r_reg, num_lo[cnt_reg]};
        ge       = rs >= {1'b0, den_reg};
        up       = {r_reg, 1'b0} >= {1'b0, den_reg};
        qr       = (tpc_pkg::QW+1)'(q_reg) + (tpc_pkg::QW+1)'(up);
        sum      = neg_reg ? tpc_pkg::SUMW'(a_reg) - $signed({1'b0, qr})
                           : tpc_pkg::SUMW'(a_reg) + $signed({1'b0, qr});
        fits     = (sum[tpc_pkg::SUMW-1:tpc_pkg::CW-1] == '0)
                || (sum[tpc_pkg::SUMW-1:tpc_pkg::CW-1] == '1);
        if (fits)
            sat = sum[tpc_pkg::CW-1:0];
        else if (sum[tpc_pkg::SUMW-1])
            sat = {1'b1, {(tpc_pkg::CW-1){1'b0}}};
        else
            sat = {1'b0, {(tpc_pkg::CW-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= X_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                X_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= tpc_pkg::CNTW'(tpc_pkg::MW - 1);
                        state_reg <= X_MUL;
                    end
                end
                X_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= tpc_pkg::CNTW'(tpc_pkg::QW - 1);
                        state_reg <= X_DIV;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                X_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= X_FIN;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                X_FIN:
                begin
                    res_reg   <= sat;
                    done_reg  <= 1'b1;
                    state_reg <= X_IDLE;
                end
                default:
                    state_reg <= X_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            X_IDLE:
            begin
                if (start)
                begin
                    a_reg   <= a;
                    neg_reg <= delta[tpc_pkg::MW-1];
                    mag_reg <= delta[tpc_pkg::MW-1] ? tpc_pkg::MW'(-delta)
                                                    : tpc_pkg::MW'(delta);
                    da_reg  <= da;
                    den_reg <= da - db;
                    acc_reg <= '0;
                end
            end
            X_MUL:
            begin
                acc_reg <= acc_next;
                if (cnt_reg == '0)
                begin
                    r_reg <= acc_next[tpc_pkg::NW-1:tpc_pkg::QW];
                    q_reg <= '0;
                end
            end
            X_DIV:
            begin
                r_reg <= ge ? tpc_pkg::DW'(rs - {1'b0, den_reg}) : rs[tpc_pkg::DW-1:0];
                q_reg <= {q_reg[tpc_pkg::QW-2:0], ge};
            end
            default:
                acc_reg <= acc_reg;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* rtl/tpc_back.sv */
module tpc_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    input  tpc_pkg::job_t            job,
    output logic                     job_ready,
    output logic                     empty,
    input  logic                     pop,
    output tpc_pkg::piece_t          piece
);

    typedef enum logic [2:0] {B_IDLE, B_ISSUE, B_WAIT, B_EMIT_A, B_EMIT_B} bstate_t;

    bstate_t                 state_reg;
    logic                    pair_reg;
    tpc_pkg::axis_t          axis_reg;
    logic                    two_reg;
    logic                    full_reg;
    tpc_pkg::job_t           work_reg;
    logic [1:0][1:0]         pa_reg;
    logic [1:0][1:0]         ob_reg;
    tpc_pkg::vtx_t [1:0]     xp_reg;

    logic [1:0][1:0]         pa_next;
    logic [1:0][1:0]         ob_next;

    logic                    xd_start;
    logic                    xd_done;
    logic signed [tpc_pkg::CW-1:0] xd_res;

    tpc_pkg::piece_t         of_mem [2];
    logic                    of_wp_reg;
    logic                    of_rp_reg;
    logic [1:0]              of_cnt_reg;
    logic                    of_full;
    logic                    of_push;
    logic                    of_pop;
    tpc_pkg::piece_t         emit_piece;
    tpc_pkg::vtx_t           vp0, vp1;

    // Crossing edges (inside end, outside end) for each inside pattern.
    always_comb
    begin
        case (job.ins)
            3'b001:  begin pa_next = {2'd0, 2'd0}; ob_next = {2'd2, 2'd1}; end
            3'b010:  begin pa_next = {2'd1, 2'd1}; ob_next = {2'd2, 2'd0}; end
            3'b100:  begin pa_next = {2'd2, 2'd2}; ob_next = {2'd1, 2'd0}; end
            3'b011:  begin pa_next = {2'd1, 2'd0}; ob_next = {2'd2, 2'd2}; end
            3'b101:  begin pa_next = {2'd2, 2'd0}; ob_next = {2'd1, 2'd1}; end
            3'b110:  begin pa_next = {2'd2, 2'd1}; ob_next = {2'd0, 2'd0}; end
            default: begin pa_next = {2'd1, 2'd0}; ob_next = {2'd2, 2'd2}; end
        endcase
    end

    assign job_ready = (state_reg == B_IDLE);
    assign xd_start  = (state_reg == B_ISSUE);

    tpc_xdiv u_xdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (xd_start),
        .a     (tpc_pkg::vtx_axis(work_reg.v[pa_reg[pair_reg]], axis_reg)),
        .b     (tpc_pkg::vtx_axis(work_reg.v[ob_reg[pair_reg]], axis_reg)),
        .da    (work_reg.d[pa_reg[pair_reg]]),
        .db    (work_reg.d[ob_reg[pair_reg]]),
        .done  (xd_done),
        .res   (xd_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pair_reg  <= 1'b0;
            axis_reg  <= tpc_pkg::AX_X;
            two_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        pair_reg <= 1'b0;
                        axis_reg <= tpc_pkg::AX_X;
                        two_reg  <= ($countones(job.ins) == 2);
                        full_reg <= (job.ins == 3'b111);
                        if (job.ins == 3'b111)
                            state_reg <= B_EMIT_A;
                        else if (job.ins != 3'b000)
                            state_reg <= B_ISSUE;
                    end
                end
                B_ISSUE:
                    state_reg <= B_WAIT;
                B_WAIT:
                begin
                    if (xd_done)
                    begin
                        if (axis_reg == tpc_pkg::AX_Z)
                        begin
                            axis_reg <= tpc_pkg::AX_X;
                            if (pair_reg)
                                state_reg <= B_EMIT_A;
                            else
                            begin
                                pair_reg  <= 1'b1;
                                state_reg <= B_ISSUE;
                            end
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= B_ISSUE;
                        end
                    end
                end
                B_EMIT_A:
                begin
                    if (!of_full)
                        state_reg <= two_reg ? B_EMIT_B : B_IDLE;
                end
                B_EMIT_B:
                begin
                    if (!of_full)
                        state_reg <= B_IDLE;
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && job_valid)
        begin
            work_reg <= job;
            pa_reg   <= pa_next;
            ob_reg   <= ob_next;
        end
        if (state_reg == B_WAIT && xd_done)
        begin
            case (axis_reg)
                tpc_pkg::AX_X: xp_reg[pair_reg].x <= xd_res;
                tpc_pkg::AX_Y: xp_reg[pair_reg].y <= xd_res;
                default:       xp_reg[pair_reg].z <= xd_res;
            endcase
        end
    end

    // Result assembly.
    always_comb
    begin
        vp0 = work_reg.v[pa_reg[0]];
        vp1 = work_reg.v[pa_reg[1]];
        emit_piece.shade = work_reg.shade;
        if (state_reg == B_EMIT_B)
        begin
            emit_piece.v    = {xp_reg[1], xp_reg[0], vp1};
            emit_piece.last = 1'b1;
        end
        else if (full_reg)
        begin
            emit_piece.v    = work_reg.v;
            emit_piece.last = 1'b1;
        end
        else if (two_reg)
        begin
            emit_piece.v    = {xp_reg[0], vp1, vp0};
            emit_piece.last = 1'b0;
        end
        else
        begin
            emit_piece.v    = {xp_reg[1], xp_reg[0], vp0};
            emit_piece.last = 1'b1;
        end
    end

    // Two-entry result queue.
    assign of_full = (of_cnt_reg == 2'd2);
    assign empty   = (of_cnt_reg == 2'd0);
    assign of_push = (state_reg == B_EMIT_A || state_reg == B_EMIT_B) && !of_full;
    assign of_pop  = pop && !empty;
    assign piece   = of_mem[of_rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            of_wp_reg  <= 1'b0;
            of_rp_reg  <= 1'b0;
            of_cnt_reg <= 2'd0;
        end
        else
        begin
            if (of_push)
                of_wp_reg <= !of_wp_reg;
            if (of_pop)
                of_rp_reg <= !of_rp_reg;
            of_cnt_reg <= of_cnt_reg + 2'(of_push) - 2'(of_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (of_push)
            of_mem[of_wp_reg] <= emit_piece;
    end

endmodule

/* rtl/triangle_plane_clipper_top.sv */
// Clips one triangle per input transaction against a plane held in the
// configuration registers (a point and an inward normal, all signed Q16.16).
// Each transaction yields no result, one result triangle, or two that form
// the clipped quad; last_piece marks the final result of a triangle. The
// front end is a three-stage pipeline (products, dot products, distances)
// that accepts one triangle per cycle until the two-entry queue to the back
// end fills. The back end drops a triangle that lies fully outside while
// idle and sends one that lies fully inside straight to its emit state. A
// clipped triangle needs six crossing coordinates, each from one shared
// serial unit doing a 33-step multiply and a 33-step divide; the back end
// issues one coordinate at a time and waits for it, so that unit sets the
// sustained rate for clipped triangles. The earliest result reaches the
// output ports through the three front stages, the job queue, the back
// end's emit state and the result queue. Results wait in a two-entry queue,
// so the result side may stall without stopping work already in progress.
// Plane registers must only be written while the block is idle.
module triangle_plane_clipper_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [tpc_pkg::CW-1:0] corner0_x,
    input  logic signed [tpc_pkg::CW-1:0] corner0_y,
    input  logic signed [tpc_pkg::CW-1:0] corner0_z,
    input  logic signed [tpc_pkg::CW-1:0] corner1_x,
    input  logic signed [tpc_pkg::CW-1:0] corner1_y,
    input  logic signed [tpc_pkg::CW-1:0] corner1_z,
    input  logic signed [tpc_pkg::CW-1:0] corner2_x,
    input  logic signed [tpc_pkg::CW-1:0] corner2_y,
    input  logic signed [tpc_pkg::CW-1:0] corner2_z,
    input  logic [tpc_pkg::SW-1:0]        shade,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [tpc_pkg::CW-1:0] out0_x,
    output logic signed [tpc_pkg::CW-1:0] out0_y,
    output logic signed [tpc_pkg::CW-1:0] out0_z,
    output logic signed [tpc_pkg::CW-1:0] out1_x,
    output logic signed [tpc_pkg::CW-1:0] out1_y,
    output logic signed [tpc_pkg::CW-1:0] out1_z,
    output logic signed [tpc_pkg::CW-1:0] out2_x,
    output logic signed [tpc_pkg::CW-1:0] out2_y,
    output logic signed [tpc_pkg::CW-1:0] out2_z,
    output logic [tpc_pkg::SW-1:0]        out_shade,
    output logic                          last_piece,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpc_pkg::AW-1:0]        paddr,
    input  logic [tpc_pkg::CW-1:0]        pwdata,
    output logic [tpc_pkg::CW-1:0]        prdata,
    output logic                          pready
);

    // Plane registers. The address selects a 32-bit word; the two low bits
    // are ignored; unused words do not store writes and read as zero.
    tpc_pkg::vtx_t    plane_p_reg;
    tpc_pkg::vtx_t    plane_n_reg;
    tpc_pkg::reg_idx_t cfg_idx;
    logic             cfg_wr;

    assign cfg_idx = paddr[tpc_pkg::AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_p_reg <= '{x: '0, y: '0, z: tpc_pkg::PPZ_RESET};
            plane_n_reg <= '{x: '0, y: '0, z: tpc_pkg::PNZ_RESET};
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tpc_pkg::REG_PPX: plane_p_reg.x <= pwdata;
                tpc_pkg::REG_PPY: plane_p_reg.y <= pwdata;
                tpc_pkg::REG_PPZ: plane_p_reg.z <= pwdata;
                tpc_pkg::REG_PNX: plane_n_reg.x <= pwdata;
                tpc_pkg::REG_PNY: plane_n_reg.y <= pwdata;
                tpc_pkg::REG_PNZ: plane_n_reg.z <= pwdata;
                default:          plane_p_reg   <= plane_p_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tpc_pkg::REG_PPX: prdata = plane_p_reg.x;
            tpc_pkg::REG_PPY: prdata = plane_p_reg.y;
            tpc_pkg::REG_PPZ: prdata = plane_p_reg.z;
            tpc_pkg::REG_PNX: prdata = plane_n_reg.x;
            tpc_pkg::REG_PNY: prdata = plane_n_reg.y;
            tpc_pkg::REG_PNZ: prdata = plane_n_reg.z;
            default:          prdata = '0;
        endcase
    end

    // Front end: distances and inside/outside classification.
    tpc_pkg::vtx_t [2:0] in_v;
    logic                in_ready;
    logic                fr_valid;
    tpc_pkg::job_t       fr_job;
    logic                fr_ready;

    assign in_v[0] = '{x: corner0_x, y: corner0_y, z: corner0_z};
    assign in_v[1] = '{x: corner1_x, y: corner1_y, z: corner1_z};
    assign in_v[2] = '{x: corner2_x, y: corner2_y, z: corner2_z};
    assign full    = !in_ready;

    tpc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push && in_ready),
        .in_ready  (in_ready),
        .in_v      (in_v),
        .in_shade  (shade),
        .plane_p   (plane_p_reg),
        .plane_n   (plane_n_reg),
        .job_valid (fr_valid),
        .job       (fr_job),
        .job_ready (fr_ready)
    );

    // Two-entry queue of classified triangles between the front and back ends,
    // so that a long crossing computation does not stall the input side until the queue is full.
    tpc_pkg::job_t jq_mem [2];
    logic          jq_wp_reg;
    logic          jq_rp_reg;
    logic [1:0]    jq_cnt_reg;
    logic          jq_push;
    logic          jq_pop;
    logic          bk_ready;

    assign fr_ready = (jq_cnt_reg != 2'd2);
    assign jq_push  = fr_valid && fr_ready;
    assign jq_pop   = bk_ready && (jq_cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jq_wp_reg  <= 1'b0;
            jq_rp_reg  <= 1'b0;
            jq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (jq_push)
                jq_wp_reg <= !jq_wp_reg;
            if (jq_pop)
                jq_rp_reg <= !jq_rp_reg;
            jq_cnt_reg <= jq_cnt_reg + 2'(jq_push) - 2'(jq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (jq_push)
            jq_mem[jq_wp_reg] <= fr_job;
    end

    // Back end: crossing points and result assembly.
    tpc_pkg::piece_t piece;

    tpc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (jq_cnt_reg != 2'd0),
        .job       (jq_mem[jq_rp_reg]),
        .job_ready (bk_ready),
        .empty     (empty),
        .pop       (pop),
        .piece     (piece)
    );

    assign out0_x     = piece.v[0].x;
    assign out0_y     = piece.v[0].y;
    assign out0_z     = piece.v[0].z;
    assign out1_x     = piece.v[1].x;
    assign out1_y     = piece.v[1].y;
    assign out1_z     = piece.v[1].z;
    assign out2_x     = piece.v[2].x;
    assign out2_y     = piece.v[2].y;
    assign out2_z     = piece.v[2].z;
    assign out_shade  = piece.shade;
    assign last_piece = piece.last;

endmodule

/* rtl/tpc_checker.sv */
module tpc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pop,
    input logic                          empty,
    input logic signed [tpc_pkg::CW-1:0] out0_x,
    input logic [tpc_pkg::SW-1:0]        out_shade,
    input logic                          last_piece,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [tpc_pkg::AW-1:0]        paddr,
    input logic [tpc_pkg::CW-1:0]        pwdata,
    input logic [tpc_pkg::CW-1:0]        prdata,
    input logic                          pready
);

    // The register port never inserts wait states.
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // No result is waiting straight after reset.
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result present after reset");

    // A waiting result that is not taken stays, unchanged.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out0_x) && $stable(out_shade)
                           && $stable(last_piece))
        else $error("waiting result changed");

    // A written PPZ plane register reads back the written value.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[tpc_pkg::AW-1:2] == tpc_pkg::REG_PPZ)
        ##1 (psel && !pwrite && paddr[tpc_pkg::AW-1:2] == tpc_pkg::REG_PPZ)
        |-> prdata == $past(pwdata))
        else $error("register readback mismatch");

endmodule

bind triangle_plane_clipper_top tpc_checker u_tpc_checker (.*);

/* bench/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Distance width used by the predictor: products of two signed 32-bit
    // values summed three times fit comfortably in 72 bits.
    typedef logic signed [71:0] dist_t;
    typedef logic signed [31:0] coord_t;

    typedef struct {
        coord_t     v [9];
        logic [15:0] shade;
        logic       last;
    } tri_t;

    // Keeps the triangles still owed by the block, oldest first, and
    // compares each result transaction field by field against them.
    class clip_scoreboard;
        tri_t pending [$];
        int   mismatches;
        int   results_seen;
        int   triangles_in;

        function void note_triangle(tri_t t [$]);
            triangles_in++;
            foreach (t[i]) pending = {pending, t[i]};
        endfunction

        function void check_piece(tri_t got);
            tri_t want;
            bit   bad;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result triangle arrived with none expected");
                return;
            end
            want = pending[0];
            pending.delete(0);
            bad = (got.shade !== want.shade) || (got.last !== want.last);
            for (int i = 0; i < 9; i++)
                if (got.v[i] !== want.v[i]) bad = 1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d mismatch", results_seen);
                    for (int i = 0; i < 9; i++)
                        $display("  coord %0d expected %0d actual %0d",
                                 i, want.v[i], got.v[i]);
                    $display("  shade expected %0d actual %0d last expected %0b actual %0b",
                             want.shade, got.shade, want.last, got.last);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    coord_t c0x = 0, c0y = 0, c0z = 0, c1x = 0, c1y = 0, c1z = 0;
    coord_t c2x = 0, c2y = 0, c2z = 0;
    logic [15:0] shade_in = 0;
    logic empty;
    logic pop = 1'b0;
    coord_t o0x, o0y, o0z, o1x, o1y, o1z, o2x, o2y, o2z;
    logic [15:0] o_shade;
    logic o_last;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [tpc_pkg::AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    triangle_plane_clipper_top dut
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .corner0_x(c0x), .corner0_y(c0y), .corner0_z(c0z),
        .corner1_x(c1x), .corner1_y(c1y), .corner1_z(c1z),
        .corner2_x(c2x), .corner2_y(c2y), .corner2_z(c2z),
        .shade(shade_in), .empty(empty), .pop(pop),
        .out0_x(o0x), .out0_y(o0y), .out0_z(o0z),
        .out1_x(o1x), .out1_y(o1y), .out1_z(o1z),
        .out2_x(o2x), .out2_y(o2y), .out2_z(o2z),
        .out_shade(o_shade), .last_piece(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    clip_scoreboard sb = new();

    // The testbench's own copy of the plane registers.
    coord_t plane_pt [3];
    coord_t plane_nrm [3];
    bit     sender_done = 0;
    bit     drain_mode = 0;
    int     clipped_count = 0;

    // Crossing coordinate from vertex a towards b: exact offset
    // |b-a|*da/(da-db), rounded to nearest with ties away from a.
    function automatic coord_t cross_axis(coord_t a, coord_t b, dist_t da, dist_t db);
        logic signed [33:0]  delta;
        logic [33:0]         mag;
        logic [135:0]        num, den, q, rm;
        logic signed [35:0]  c;
        delta = 34'(b) - 34'(a);
        mag = delta < 0 ? -delta : delta;
        den = 136'(da - db);
        num = 136'(da) * 136'(mag);
        q = num / den;
        rm = num % den;
        if ((rm << 1) >= den) q = q + 1;
        c = delta < 0 ? 36'(a) - 36'(q) : 36'(a) + 36'(q);
        if (c > 36'sh07FFFFFFF) c = 36'sh07FFFFFFF;
        if (c < -36'sh080000000) c = -36'sh080000000;
        return c[31:0];
    endfunction

    function automatic dist_t plane_dot(coord_t x, coord_t y, coord_t z);
        return dist_t'(plane_nrm[0]) * x + dist_t'(plane_nrm[1]) * y
             + dist_t'(plane_nrm[2]) * z;
    endfunction

    // Works out the result triangles that one input triangle gives.
    task automatic predict_clip(coord_t cv [9], logic [15:0] sh, output tri_t res [$]);
        dist_t d [3];
        dist_t np;
        int ins [$], outs [$];
        coord_t x0 [3], x1 [3];
        tri_t t;
        res = {};
        np = plane_dot(plane_pt[0], plane_pt[1], plane_pt[2]);
        for (int k = 0; k < 3; k++)
        begin
            d[k] = plane_dot(cv[3*k], cv[3*k+1], cv[3*k+2]) - np;
            if (d[k] >= 0) ins = {ins, k}; else outs = {outs, k};
        end
        t.shade = sh;
        if (ins.size() == 0) return;
        if (ins.size() == 3)
        begin
            t.v = cv;
            t.last = 1;
            res = {res, t};
            return;
        end
        clipped_count++;
        if (ins.size() == 1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x0[k] = cross_axis(cv[3*ins[0]+k], cv[3*outs[0]+k], d[ins[0]], d[outs[0]]);
                x1[k] = cross_axis(cv[3*ins[0]+k], cv[3*outs[1]+k], d[ins[0]], d[outs[1]]);
            end
            for (int k = 0; k < 3; k++)
            begin
                t.v[k] = cv[3*ins[0]+k];
                t.v[3+k] = x0[k];
                t.v[6+k] = x1[k];
            end
            t.last = 1;
            res = {res, t};
            return;
        end
        for (int k = 0; k < 3; k++)
        begin
            x0[k] = cross_axis(cv[3*ins[0]+k], cv[3*outs[0]+k], d[ins[0]], d[outs[0]]);
            x1[k] = cross_axis(cv[3*ins[1]+k], cv[3*outs[0]+k], d[ins[1]], d[outs[0]]);
        end
        for (int k = 0; k < 3; k++)
        begin
            t.v[k] = cv[3*ins[0]+k];
            t.v[3+k] = cv[3*ins[1]+k];
            t.v[6+k] = x0[k];
        end
        t.last = 0;
        res = {res, t};
        for (int k = 0; k < 3; k++)
        begin
            t.v[k] = cv[3*ins[1]+k];
            t.v[3+k] = x0[k];
            t.v[6+k] = x1[k];
        end
        t.last = 1;
        res = {res, t};
    endtask

    // Mostly short gaps, occasionally a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // One configuration write: setup cycle, then access cycle.
    task automatic write_plane_reg(int idx, coord_t val);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1;
        paddr = tpc_pkg::AW'(4 * idx); pwdata = val;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
        if (idx < 3) plane_pt[idx] = val; else plane_nrm[idx - 3] = val;
    endtask

    // Called at a falling edge: stops sending, waits for every owed result,
    // lets the back end settle and returns at a falling edge.
    task automatic wait_idle();
        push = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    // Called at a falling edge. Hands one triangle over; push is held while
    // full stays high, and stays high into the next triangle when no gap
    // follows, so triangles can go back to back.
    task automatic send_triangle(coord_t cv [9], logic [15:0] sh);
        tri_t res [$];
        int   g;
        {c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z} =
            {cv[0], cv[1], cv[2], cv[3], cv[4], cv[5], cv[6], cv[7], cv[8]};
        shade_in = sh;
        push = 1;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_clip(cv, sh, res);
        sb.note_triangle(res);
        g = gap_len();
        @(negedge clk);
        if (g != 0)
        begin
            push = 0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            default: return $urandom_range(0, 3) == 0 ? 32'h80000000 :
                            ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h0);
        endcase
    endfunction

    task automatic random_triangle(int mode);
        coord_t cv [9];
        for (int i = 0; i < 9; i++) cv[i] = rand_coord($urandom_range(0, 9) == 0 ? 2 : mode);
        send_triangle(cv, 16'($urandom()));
    endtask

    task automatic directed_triangles();
        coord_t cv [9];
        // Fully inside, fully outside, a vertex on the plane, one and two vertices inside, extremes.
        cv = '{0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 0, 32'h10000, 32'h10000};
        send_triangle(cv, 16'hFFFF);
        cv = '{0, 0, -32'h10000, 32'h10000, 0, -32'h10000, 0, 32'h10000, -32'h10000};
        send_triangle(cv, 16'h0000);
        cv = '{0, 0, 6554, 32'h10000, 0, -32'h10000, 0, 32'h10000, -32'h10000};
        send_triangle(cv, 16'h1234);
        cv = '{0, 0, 32'h20000, 32'h10000, 0, -32'h10000, 0, 32'h10000, -32'h10000};
        send_triangle(cv, 16'h5555);
        cv = '{0, 0, 32'h20000, 32'h10000, 0, 32'h20000, 0, 32'h10000, -32'h10000};
        send_triangle(cv, 16'hAAAA);
        cv = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
               32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
        send_triangle(cv, 16'h8001);
        cv = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 0, 0, 0};
        send_triangle(cv, 16'h7FFE);
        cv = '{-1, -1, -1, 1, 1, 1, 5, 5, 6554};
        send_triangle(cv, 16'h0001);
    endtask

    // Result side: pops with random stalls.
    initial
    begin
        tri_t got;
        forever
        begin
            @(negedge clk);
            pop = (drain_mode || $urandom_range(0, 9) < 7) && gap_len() == 0 ? 1 : 0;
            if (!pop && $urandom_range(0, 15) == 0)
                repeat (gap_len()) @(negedge clk);
            pop = drain_mode ? 1 : pop | ($urandom_range(0, 2) != 0);
            @(posedge clk);
            if (pop && !empty)
            begin
                got.v = '{o0x, o0y, o0z, o1x, o1y, o1z, o2x, o2y, o2z};
                got.shade = o_shade;
                got.last = o_last;
                sb.check_piece(got);
            end
        end
    end

    // Stimulus: directed part under reset values, then random phases
    // across several plane settings including the extremes.
    initial
    begin
        coord_t setting [6];
        plane_pt = '{0, 0, 6554};
        plane_nrm = '{0, 0, 65536};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        directed_triangles();
        wait_idle();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: setting = '{0, 0, 0, 0, 0, 0};
                1: setting = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                               32'h80000000, 32'h7FFFFFFF, 32'h80000000};
                2: setting = '{32'h10000, -32'h8000, 0, 32'h10000, 32'h10000, -32'h20000};
                default:
                    for (int i = 0; i < 6; i++)
                        setting[i] = $urandom_range(0, 1) ? $urandom() :
                                     rand_coord(1);
            endcase
            for (int i = 0; i < 6; i++) write_plane_reg(i, setting[i]);
            for (int n = 0; n < 100; n++)
            begin
                random_triangle($urandom_range(0, 3) == 0 ? 0 : 1);
                // Hold off once per phase until the block has drained.
                if (n == 50) wait_idle();
            end
            wait_idle();
        end
        sender_done = 1;
    end

    initial
    begin
        wait (sender_done);
        drain_mode = 1;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Run covered %0d triangles (%0d clipped) and %0d result transactions",
                 sb.triangles_in, clipped_count, sb.results_seen);
        $display("over seven plane settings; %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Worst case is some 600 clipped triangles, each holding the back end for six crossing
    // coordinates, plus long gaps on both sides; this allows several times that.
    initial
    begin
        #5000000;
        $display("TIMEOUT");
        $display("TEST FAILED");
        $finish;
    end

endmodule
